### design/fss_pkg.sv
`default_nettype none
package fss_pkg;

	localparam int LEN_W   = 21;
	localparam int ROOT_W  = 22;
	localparam int RAD_W   = 2 * ROOT_W;
	localparam int ACC_W   = 96;
	localparam int PC_W    = 5;
	localparam int DIV3_SH = 43;

	localparam logic [33:0] PI_Q32 = 34'h3243F6A89;
	// ceil(2^43 / 3); exact floor divide for x < 2^43
	localparam logic [41:0] DIV3_M = 42'h2AAAAAAAAAB;

	// step kinds
	localparam logic [1:0] K_MUL    = 2'd0;
	localparam logic [1:0] K_RSTART = 2'd1;
	localparam logic [1:0] K_RWAIT  = 2'd2;
	localparam logic [1:0] K_DONE   = 2'd3;

	// operand sources
	localparam logic [4:0] SRC_ZERO  = 5'd0;
	localparam logic [4:0] SRC_DX    = 5'd1;
	localparam logic [4:0] SRC_DY    = 5'd2;
	localparam logic [4:0] SRC_DZ    = 5'd3;
	localparam logic [4:0] SRC_RD    = 5'd4;
	localparam logic [4:0] SRC_R1    = 5'd5;
	localparam logic [4:0] SRC_R2    = 5'd6;
	localparam logic [4:0] SRC_RSUM  = 5'd7;
	localparam logic [4:0] SRC_H     = 5'd8;
	localparam logic [4:0] SRC_SLANT = 5'd9;
	localparam logic [4:0] SRC_SLO   = 5'd10;
	localparam logic [4:0] SRC_SHI   = 5'd11;
	localparam logic [4:0] SRC_OLO   = 5'd12;
	localparam logic [4:0] SRC_OHI   = 5'd13;
	localparam logic [4:0] SRC_PILO  = 5'd14;
	localparam logic [4:0] SRC_PIHI  = 5'd15;
	localparam logic [4:0] SRC_M3LO  = 5'd16;
	localparam logic [4:0] SRC_M3HI  = 5'd17;

	// where the accumulator goes after a multiply step
	localparam logic [2:0] DST_NONE = 3'd0;
	localparam logic [2:0] DST_D2   = 3'd1;
	localparam logic [2:0] DST_E    = 3'd2;
	localparam logic [2:0] DST_S    = 3'd3;
	localparam logic [2:0] DST_OP   = 3'd4;
	localparam logic [2:0] DST_XV   = 3'd5;
	localparam logic [2:0] DST_VOL  = 3'd6;
	localparam logic [2:0] DST_AREA = 3'd7;

	localparam logic [PC_W-1:0] STEP_LAST = 5'd26;

	typedef struct packed {
		logic [1:0] kind;
		logic [4:0] a_sel;
		logic [4:0] b_sel;
		logic [1:0] sh;    // product shifted left by 32*sh
		logic       clr;
		logic [2:0] dest;
		logic       rsel;  // root operand: 0 = d2, 1 = d2 + rd^2
	} step_t;

	function automatic step_t mk(input logic [1:0] kind, input logic [4:0] a,
		input logic [4:0] b, input logic [1:0] sh, input logic clr,
		input logic [2:0] dest, input logic rsel);
		step_t s;
		s.kind  = kind;
		s.a_sel = a;
		s.b_sel = b;
		s.sh    = sh;
		s.clr   = clr;
		s.dest  = dest;
		s.rsel  = rsel;
		return s;
	endfunction

	function automatic step_t prog(input logic [PC_W-1:0] pc);
		step_t s;
		case (pc)
			5'd0:  s = mk(K_MUL, SRC_DX, SRC_DX, 2'd0, 1'b1, DST_NONE, 1'b0);
			5'd1:  s = mk(K_MUL, SRC_DY, SRC_DY, 2'd0, 1'b0, DST_NONE, 1'b0);
			5'd2:  s = mk(K_MUL, SRC_DZ, SRC_DZ, 2'd0, 1'b0, DST_D2, 1'b0);
			5'd3:  s = mk(K_MUL, SRC_RD, SRC_RD, 2'd0, 1'b0, DST_E, 1'b0);
			5'd4:  s = mk(K_RSTART, SRC_ZERO, SRC_ZERO, 2'd0, 1'b0, DST_NONE, 1'b0);
			5'd5:  s = mk(K_MUL, SRC_R1, SRC_R1, 2'd0, 1'b1, DST_NONE, 1'b0);
			5'd6:  s = mk(K_MUL, SRC_R2, SRC_R2, 2'd0, 1'b0, DST_NONE, 1'b0);
			5'd7:  s = mk(K_MUL, SRC_R1, SRC_R2, 2'd0, 1'b0, DST_S, 1'b0);
			5'd8:  s = mk(K_RWAIT, SRC_ZERO, SRC_ZERO, 2'd0, 1'b0, DST_NONE, 1'b0);
			5'd9:  s = mk(K_RSTART, SRC_ZERO, SRC_ZERO, 2'd0, 1'b0, DST_NONE, 1'b1);
			5'd10: s = mk(K_MUL, SRC_H, SRC_SLO, 2'd0, 1'b1, DST_NONE, 1'b0);
			5'd11: s = mk(K_MUL, SRC_H, SRC_SHI, 2'd1, 1'b0, DST_OP, 1'b0);
			5'd12: s = mk(K_MUL, SRC_OLO, SRC_PILO, 2'd0, 1'b1, DST_NONE, 1'b0);
			5'd13: s = mk(K_MUL, SRC_OLO, SRC_PIHI, 2'd1, 1'b0, DST_NONE, 1'b0);
			5'd14: s = mk(K_MUL, SRC_OHI, SRC_PILO, 2'd1, 1'b0, DST_NONE, 1'b0);
			5'd15: s = mk(K_MUL, SRC_OHI, SRC_PIHI, 2'd2, 1'b0, DST_XV, 1'b0);
			5'd16: s = mk(K_MUL, SRC_OLO, SRC_M3LO, 2'd0, 1'b1, DST_NONE, 1'b0);
			5'd17: s = mk(K_MUL, SRC_OLO, SRC_M3HI, 2'd1, 1'b0, DST_NONE, 1'b0);
			5'd18: s = mk(K_MUL, SRC_OHI, SRC_M3LO, 2'd1, 1'b0, DST_NONE, 1'b0);
			5'd19: s = mk(K_MUL, SRC_OHI, SRC_M3HI, 2'd2, 1'b0, DST_VOL, 1'b0);
			5'd20: s = mk(K_RWAIT, SRC_ZERO, SRC_ZERO, 2'd0, 1'b0, DST_NONE, 1'b1);
			5'd21: s = mk(K_MUL, SRC_RSUM, SRC_SLANT, 2'd0, 1'b1, DST_OP, 1'b0);
			5'd22: s = mk(K_MUL, SRC_OLO, SRC_PILO, 2'd0, 1'b1, DST_NONE, 1'b0);
			5'd23: s = mk(K_MUL, SRC_OLO, SRC_PIHI, 2'd1, 1'b0, DST_NONE, 1'b0);
			5'd24: s = mk(K_MUL, SRC_OHI, SRC_PILO, 2'd1, 1'b0, DST_NONE, 1'b0);
			5'd25: s = mk(K_MUL, SRC_OHI, SRC_PIHI, 2'd2, 1'b0, DST_AREA, 1'b0);
			default: s = mk(K_DONE, SRC_ZERO, SRC_ZERO, 2'd0, 1'b0, DST_NONE, 1'b0);
		endcase
		return s;
	endfunction

endpackage
`default_nettype wire

### design/fss_mul.sv
`default_nettype none
module fss_mul
	import fss_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        en,
	input  wire logic [31:0] a,
	input  wire logic [31:0] b,
	output logic      [63:0] p
);

	always_ff @(posedge clk) begin
		if (en) begin
			p <= a * b;
		end
	end

endmodule
`default_nettype wire

### design/fss_root.sv
`default_nettype none
module fss_root
	import fss_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire logic [RAD_W-1:0] radicand,
	output logic                  busy,
	output logic [ROOT_W-1:0]     root
);

	logic [RAD_W-1:0]  rad_q;
	logic [ROOT_W+1:0] rem_q;
	logic [ROOT_W-1:0] root_q;
	logic [4:0]        cnt_q;
	logic              busy_q;
	logic [ROOT_W+1:0] rem_t;
	logic [ROOT_W+1:0] trial;
	logic              fits;

	// one result bit per cycle, restoring
	assign rem_t = {rem_q[ROOT_W-1:0], rad_q[RAD_W-1 -: 2]};
	assign trial = {root_q, 2'b01};
	assign fits  = rem_t >= trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= 5'(ROOT_W - 1);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 5'd1;
			if (cnt_q == '0) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rad_q  <= radicand;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			rad_q  <= {rad_q[RAD_W-3:0], 2'b00};
			rem_q  <= fits ? rem_t - trial : rem_t;
			root_q <= {root_q[ROOT_W-2:0], fits};
		end
	end

	assign busy = busy_q;
	assign root = root_q;

endmodule
`default_nettype wire

### design/frustum_segment_stats_accumulator.sv
`default_nettype none
// Frustum segment statistics. Each word is one tube segment (two endpoints with
// radii, FRACTION_BITS fraction bits); the result word gives the segment's length,
// frustum volume and lateral area plus saturating running totals, extremes and a
// count, which restart clears before the segment is counted. A sequencer issues
// 22 multiplies on a single 32x32 multiplier and two integer square roots on a
// shared root unit that yields one bit per cycle, partly overlapped. The input
// stalls while a segment is in work and opens the cycle after the result is
// posted, so a new segment is accepted only once the sequencer has finished the
// previous one. A result still waiting only holds off the final step of the next
// segment; a new segment can be accepted while the previous result still waits.
module frustum_segment_stats_accumulator
	import fss_pkg::*;
#(
	parameter int FRACTION_BITS = 8
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         in_valid,
	output logic              in_stall,
	input  wire logic [19:0]  start_x,
	input  wire logic [19:0]  start_y,
	input  wire logic [19:0]  start_z,
	input  wire logic [15:0]  start_radius,
	input  wire logic [19:0]  end_x,
	input  wire logic [19:0]  end_y,
	input  wire logic [19:0]  end_z,
	input  wire logic [15:0]  end_radius,
	input  wire logic         restart,
	output logic              out_valid,
	input  wire logic         out_stall,
	output logic [39:0]       segment_volume,
	output logic [31:0]       segment_area,
	output logic [20:0]       segment_length,
	output logic [47:0]       sum_volume,
	output logic [47:0]       sum_area,
	output logic [47:0]       sum_length,
	output logic [20:0]       longest,
	output logic [20:0]       shortest,
	output logic [31:0]       segment_total
);

	localparam int VOL_SH  = 2 * FRACTION_BITS + 32;
	localparam int AREA_SH = FRACTION_BITS + 32;

	logic            busy_q;
	logic [PC_W-1:0] pc_q;
	logic            phase_q;
	logic            out_valid_q;

	logic [20:0] dx_q, dy_q, dz_q;
	logic [15:0] r1_q, r2_q, rd_q;
	logic [16:0] rsum_q;
	logic        restart_q;
	logic [42:0] d2_q;
	logic [42:0] e_q;
	logic [33:0] s_q;
	logic [LEN_W-1:0]  h_q;
	logic [ROOT_W-1:0] slant_q;
	logic [63:0] op_q;
	logic        big_q;
	logic [39:0] vol_q;
	logic [31:0] area_q;
	logic [ACC_W-1:0] acc_q;

	logic [39:0] seg_vol_q;
	logic [31:0] seg_area_q;
	logic [20:0] seg_len_q;
	logic [47:0] vol_acc_q, area_acc_q, len_acc_q;
	logic [20:0] max_q, min_q;
	logic [31:0] cnt_q;

	step_t       st;
	logic        accept;
	logic        out_free;
	logic        done_fire;
	logic [31:0] mul_a, mul_b;
	logic [63:0] mul_p;
	logic        mul_en;
	logic [ACC_W-1:0] acc_next;
	logic [ACC_W-1:0] addend;
	logic [ACC_W-1:0] xv;
	logic [ACC_W-1:0] vq;
	logic [ACC_W-1:0] ay;
	logic        root_start;
	logic        root_busy;
	logic [ROOT_W-1:0] root_res;
	logic [RAD_W-1:0]  root_in;

	logic signed [20:0] dxs, dys, dzs;
	logic [47:0] vbase, abase, lbase;
	logic [48:0] vsum, asum, lsum;
	logic [20:0] maxb, minb;
	logic [31:0] cntb;

	assign accept    = in_valid && !busy_q;
	assign in_stall  = busy_q;
	assign out_free  = !out_valid_q || !out_stall;
	assign st        = prog(pc_q);
	assign done_fire = busy_q && st.kind == K_DONE && out_free;

	assign dxs = {start_x[19], start_x} - {end_x[19], end_x};
	assign dys = {start_y[19], start_y} - {end_y[19], end_y};
	assign dzs = {start_z[19], start_z} - {end_z[19], end_z};

	function automatic logic [31:0] pick(input logic [4:0] sel, input logic [20:0] dx,
		input logic [20:0] dy, input logic [20:0] dz, input logic [15:0] rd,
		input logic [15:0] r1, input logic [15:0] r2, input logic [16:0] rsum,
		input logic [20:0] h, input logic [21:0] slant, input logic [33:0] s,
		input logic [63:0] op);
		logic [31:0] v;
		case (sel)
			SRC_DX:    v = {11'b0, dx};
			SRC_DY:    v = {11'b0, dy};
			SRC_DZ:    v = {11'b0, dz};
			SRC_RD:    v = {16'b0, rd};
			SRC_R1:    v = {16'b0, r1};
			SRC_R2:    v = {16'b0, r2};
			SRC_RSUM:  v = {15'b0, rsum};
			SRC_H:     v = {11'b0, h};
			SRC_SLANT: v = {10'b0, slant};
			SRC_SLO:   v = s[31:0];
			SRC_SHI:   v = {30'b0, s[33:32]};
			SRC_OLO:   v = op[31:0];
			SRC_OHI:   v = op[63:32];
			SRC_PILO:  v = PI_Q32[31:0];
			SRC_PIHI:  v = {30'b0, PI_Q32[33:32]};
			SRC_M3LO:  v = DIV3_M[31:0];
			SRC_M3HI:  v = {22'b0, DIV3_M[41:32]};
			default:   v = '0;
		endcase
		return v;
	endfunction

	assign mul_a  = pick(st.a_sel, dx_q, dy_q, dz_q, rd_q, r1_q, r2_q, rsum_q,
		h_q, slant_q, s_q, op_q);
	assign mul_b  = pick(st.b_sel, dx_q, dy_q, dz_q, rd_q, r1_q, r2_q, rsum_q,
		h_q, slant_q, s_q, op_q);
	assign mul_en = busy_q && st.kind == K_MUL && !phase_q;

	fss_mul u_mul (
		.clk (clk),
		.en  (mul_en),
		.a   (mul_a),
		.b   (mul_b),
		.p   (mul_p)
	);

	assign root_start = busy_q && st.kind == K_RSTART;
	assign root_in    = st.rsel ? {1'b0, e_q} : {1'b0, d2_q};

	fss_root u_root (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (root_start),
		.radicand (root_in),
		.busy     (root_busy),
		.root     (root_res)
	);

	always_comb begin
		case (st.sh)
			2'd0:    addend = {32'b0, mul_p};
			2'd1:    addend = {mul_p, 32'b0};
			default: addend = {mul_p[31:0], 64'b0};
		endcase
	end

	assign acc_next = (st.clr ? '0 : acc_q) + addend;
	assign xv = acc_next >> VOL_SH;
	assign vq = acc_next >> DIV3_SH;
	assign ay = acc_next >> AREA_SH;

	// totals with restart folded in
	assign vbase = restart_q ? '0 : vol_acc_q;
	assign abase = restart_q ? '0 : area_acc_q;
	assign lbase = restart_q ? '0 : len_acc_q;
	assign maxb  = restart_q ? '0 : max_q;
	assign minb  = restart_q ? '1 : min_q;
	assign cntb  = restart_q ? '0 : cnt_q;
	assign vsum  = {1'b0, vbase} + {9'b0, vol_q};
	assign asum  = {1'b0, abase} + {17'b0, area_q};
	assign lsum  = {1'b0, lbase} + {28'b0, h_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			pc_q        <= '0;
			phase_q     <= 1'b0;
			out_valid_q <= 1'b0;
			vol_acc_q   <= '0;
			area_acc_q  <= '0;
			len_acc_q   <= '0;
			max_q       <= '0;
			min_q       <= '1;
			cnt_q       <= '0;
		end else begin
			if (out_valid_q && !out_stall && !done_fire) begin
				out_valid_q <= 1'b0;
			end
			if (accept) begin
				busy_q  <= 1'b1;
				pc_q    <= '0;
				phase_q <= 1'b0;
			end else if (busy_q) begin
				case (st.kind)
					K_MUL: begin
						phase_q <= !phase_q;
						if (phase_q) begin
							pc_q <= pc_q + 5'd1;
						end
					end
					K_RSTART: pc_q <= pc_q + 5'd1;
					K_RWAIT: begin
						if (!root_busy) begin
							pc_q <= pc_q + 5'd1;
						end
					end
					default: begin
						if (out_free) begin
							busy_q      <= 1'b0;
							out_valid_q <= 1'b1;
							vol_acc_q   <= vsum[48] ? '1 : vsum[47:0];
							area_acc_q  <= asum[48] ? '1 : asum[47:0];
							len_acc_q   <= lsum[48] ? '1 : lsum[47:0];
							max_q       <= (h_q > maxb) ? h_q : maxb;
							min_q       <= (h_q < minb) ? h_q : minb;
							cnt_q       <= (cntb == '1) ? cntb : cntb + 32'd1;
						end
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			dx_q      <= dxs[20] ? 21'(-dxs) : dxs;
			dy_q      <= dys[20] ? 21'(-dys) : dys;
			dz_q      <= dzs[20] ? 21'(-dzs) : dzs;
			r1_q      <= start_radius;
			r2_q      <= end_radius;
			rd_q      <= (start_radius > end_radius) ? start_radius - end_radius
				: end_radius - start_radius;
			rsum_q    <= {1'b0, start_radius} + {1'b0, end_radius};
			restart_q <= restart;
		end
		if (busy_q && st.kind == K_MUL && phase_q) begin
			acc_q <= acc_next;
			case (st.dest)
				DST_D2: d2_q <= acc_next[42:0];
				DST_E:  e_q  <= acc_next[42:0];
				DST_S:  s_q  <= acc_next[33:0];
				DST_OP: op_q <= acc_next[63:0];
				DST_XV: begin
					op_q  <= xv[63:0];
					big_q <= |xv[ACC_W-1:42];
				end
				DST_VOL:  vol_q  <= (big_q || |vq[ACC_W-1:40]) ? '1 : vq[39:0];
				DST_AREA: area_q <= (|ay[ACC_W-1:32]) ? '1 : ay[31:0];
				default: ;
			endcase
		end
		if (busy_q && st.kind == K_RWAIT && !root_busy) begin
			if (st.rsel) begin
				slant_q <= root_res;
			end else begin
				h_q <= root_res[LEN_W-1:0];
			end
		end
		if (done_fire) begin
			seg_vol_q  <= vol_q;
			seg_area_q <= area_q;
			seg_len_q  <= h_q;
		end
	end

	assign out_valid      = out_valid_q;
	assign segment_volume = seg_vol_q;
	assign segment_area   = seg_area_q;
	assign segment_length = seg_len_q;
	assign sum_volume     = vol_acc_q;
	assign sum_area       = area_acc_q;
	assign sum_length     = len_acc_q;
	assign longest        = max_q;
	assign shortest       = min_q;
	assign segment_total  = cnt_q;

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> busy_q)
		else $error("accepted word did not start the sequencer");

	a_result_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(busy_q) && !busy_q)
		else $error("result raised outside the final step");

	a_pc_range: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> pc_q <= STEP_LAST)
		else $error("sequencer ran past its program");

	a_extremes: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != '0 |-> min_q <= max_q)
		else $error("shortest exceeds longest");

	a_totals_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_stall |=> $stable(cnt_q) && $stable(vol_acc_q))
		else $error("totals changed under a stalled result");

endmodule
`default_nettype wire

### dv/tb_frustum_segment_stats_accumulator.sv
`timescale 1ns / 1ps
module tb_frustum_segment_stats_accumulator;
	import fss_pkg::*;

	localparam int FB = 8;
	localparam int QUIET_LIMIT = 20000;
	localparam int N_RANDOM = 1300;

	typedef struct packed {
		logic [19:0] sx, sy, sz;
		logic [15:0] sr;
		logic [19:0] ex, ey, ez;
		logic [15:0] er;
		logic        rst;
	} seg_t;

	typedef struct packed {
		logic [39:0] vol;
		logic [31:0] area;
		logic [20:0] len;
		logic [47:0] svol, sarea, slen;
		logic [20:0] lmax, lmin;
		logic [31:0] cnt;
	} stats_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [19:0] start_x = '0, start_y = '0, start_z = '0;
	logic [15:0] start_radius = '0;
	logic [19:0] end_x = '0, end_y = '0, end_z = '0;
	logic [15:0] end_radius = '0;
	logic restart = 1'b0;
	logic [39:0] segment_volume;
	logic [31:0] segment_area;
	logic [20:0] segment_length;
	logic [47:0] sum_volume, sum_area, sum_length;
	logic [20:0] longest, shortest;
	logic [31:0] segment_total;

	frustum_segment_stats_accumulator dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.start_x(start_x), .start_y(start_y), .start_z(start_z),
		.start_radius(start_radius),
		.end_x(end_x), .end_y(end_y), .end_z(end_z), .end_radius(end_radius),
		.restart(restart),
		.out_valid(out_valid), .out_stall(out_stall),
		.segment_volume(segment_volume), .segment_area(segment_area),
		.segment_length(segment_length),
		.sum_volume(sum_volume), .sum_area(sum_area), .sum_length(sum_length),
		.longest(longest), .shortest(shortest), .segment_total(segment_total)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// running statistics held by the predictor
	logic [47:0] acc_vol, acc_area, acc_len;
	logic [20:0] len_max, len_min;
	logic [31:0] seg_cnt;

	seg_t   pending_words[$];
	stats_t expected_stats[$];
	int     errors = 0;
	bit     no_idle = 0;
	bit     hold_rx = 0;
	bit     hold_tx = 0;

	function automatic logic [63:0] isqrt(input logic [63:0] v);
		logic [63:0] res, bitv;
		res = 0;
		bitv = 64'd1 << 62;
		while (bitv > v) bitv >>= 2;
		while (bitv != 0) begin
			if (v >= res + bitv) begin
				v = v - (res + bitv);
				res = (res >> 1) + bitv;
			end else begin
				res = res >> 1;
			end
			bitv >>= 2;
		end
		return res;
	endfunction

	function automatic logic [47:0] sat_add48(input logic [47:0] a, input logic [63:0] b);
		logic [63:0] s;
		s = {16'd0, a} + b;
		return (s > 64'hFFFF_FFFF_FFFF) ? 48'hFFFF_FFFF_FFFF : s[47:0];
	endfunction

	function automatic stats_t frustum_stats(input seg_t w);
		stats_t r;
		logic signed [63:0] dx, dy, dz;
		logic [63:0] d2, h, slant, r1, r2, rd;
		logic [127:0] p, v, a;
		dx = $signed(w.sx) - $signed(w.ex);
		dy = $signed(w.sy) - $signed(w.ey);
		dz = $signed(w.sz) - $signed(w.ez);
		d2 = $unsigned(dx * dx + dy * dy + dz * dz);
		h = isqrt(d2) & 64'h1F_FFFF;
		r1 = 64'(w.sr);
		r2 = 64'(w.er);
		p = 128'(h) * 128'(r1 * r1 + r2 * r2 + r1 * r2) * 128'(PI_Q32);
		v = (p >> (2 * FB + 32)) / 3;
		if (v > 128'hFF_FFFF_FFFF) v = 128'hFF_FFFF_FFFF;
		rd = (r1 > r2) ? r1 - r2 : r2 - r1;
		slant = isqrt(d2 + rd * rd);
		a = (128'(r1 + r2) * 128'(slant) * 128'(PI_Q32)) >> (FB + 32);
		if (a > 128'hFFFF_FFFF) a = 128'hFFFF_FFFF;
		if (w.rst) begin
			acc_vol = 0; acc_area = 0; acc_len = 0;
			len_max = 0; len_min = '1; seg_cnt = 0;
		end
		acc_vol = sat_add48(acc_vol, v[63:0]);
		acc_area = sat_add48(acc_area, a[63:0]);
		acc_len = sat_add48(acc_len, h);
		if (h[20:0] > len_max) len_max = h[20:0];
		if (h[20:0] < len_min) len_min = h[20:0];
		if (seg_cnt != 32'hFFFF_FFFF) seg_cnt++;
		r.vol = v[39:0]; r.area = a[31:0]; r.len = h[20:0];
		r.svol = acc_vol; r.sarea = acc_area; r.slen = acc_len;
		r.lmax = len_max; r.lmin = len_min; r.cnt = seg_cnt;
		return r;
	endfunction

	function automatic logic [19:0] rand_coord(input int mode);
		case (mode)
			0: return 20'h80000;
			1: return 20'h7FFFF;
			2: return 20'($urandom_range(0, 4000)) - 20'd2000;
			default: return 20'($urandom);
		endcase
	endfunction

	function automatic seg_t rand_seg();
		seg_t w;
		int m;
		m = $urandom_range(0, 9);
		w.sx = rand_coord(m < 1 ? $urandom_range(0, 1) : m < 5 ? 2 : 3);
		w.sy = rand_coord(m < 1 ? $urandom_range(0, 1) : m < 5 ? 2 : 3);
		w.sz = rand_coord(m < 1 ? $urandom_range(0, 1) : m < 5 ? 2 : 3);
		w.ex = rand_coord(m < 1 ? $urandom_range(0, 1) : m < 5 ? 2 : 3);
		w.ey = rand_coord(m < 1 ? $urandom_range(0, 1) : m < 5 ? 2 : 3);
		w.ez = rand_coord(m < 1 ? $urandom_range(0, 1) : m < 5 ? 2 : 3);
		if (m == 9) begin
			w.ex = w.sx; w.ey = w.sy; w.ez = w.sz;
		end
		w.sr = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 2000));
		w.er = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 2000));
		w.rst = ($urandom_range(0, 40) == 0);
		return w;
	endfunction

	function automatic seg_t mk_seg(input logic [19:0] sx, sy, sz, input logic [15:0] sr,
		input logic [19:0] ex, ey, ez, input logic [15:0] er, input logic rst);
		seg_t w;
		w.sx = sx; w.sy = sy; w.sz = sz; w.sr = sr;
		w.ex = ex; w.ey = ey; w.ez = ez; w.er = er; w.rst = rst;
		return w;
	endfunction

	// driver
	int tx_gap = 0;
	always @(posedge clk) begin
		if (in_valid && !in_stall) begin
			expected_stats.push_back(frustum_stats({start_x, start_y, start_z, start_radius,
				end_x, end_y, end_z, end_radius, restart}));
		end
		if (!in_valid || !in_stall) begin
			if (tx_gap > 0) begin
				tx_gap <= tx_gap - 1;
				in_valid <= 1'b0;
			end else if (!hold_tx && pending_words.size() > 0 &&
				(no_idle || $urandom_range(0, 9) != 0)) begin
				seg_t w;
				w = pending_words.pop_front();
				{start_x, start_y, start_z, start_radius,
					end_x, end_y, end_z, end_radius, restart} <= w;
				in_valid <= 1'b1;
			end else begin
				in_valid <= 1'b0;
				if (!no_idle && $urandom_range(0, 9) == 0) tx_gap <= $urandom_range(0, 8);
			end
		end
	end

	// monitor and receiver idling
	int rx_gap = 0;
	always @(posedge clk) begin
		if (out_valid && !out_stall) begin
			if (expected_stats.size() == 0) begin
				$display("%0t: unexpected result volume %h", $time, segment_volume);
				errors++;
			end else begin
				stats_t e, g;
				e = expected_stats.pop_front();
				g = {segment_volume, segment_area, segment_length, sum_volume, sum_area,
					sum_length, longest, shortest, segment_total};
				if (g.vol !== e.vol) begin
					$display("%0t: volume exp %h got %h", $time, e.vol, g.vol); errors++;
				end
				if (g.area !== e.area) begin
					$display("%0t: area exp %h got %h", $time, e.area, g.area); errors++;
				end
				if (g.len !== e.len) begin
					$display("%0t: length exp %h got %h", $time, e.len, g.len); errors++;
				end
				if (g.svol !== e.svol) begin
					$display("%0t: sum_volume exp %h got %h", $time, e.svol, g.svol); errors++;
				end
				if (g.sarea !== e.sarea) begin
					$display("%0t: sum_area exp %h got %h", $time, e.sarea, g.sarea); errors++;
				end
				if (g.slen !== e.slen) begin
					$display("%0t: sum_length exp %h got %h", $time, e.slen, g.slen); errors++;
				end
				if (g.lmax !== e.lmax) begin
					$display("%0t: longest exp %h got %h", $time, e.lmax, g.lmax); errors++;
				end
				if (g.lmin !== e.lmin) begin
					$display("%0t: shortest exp %h got %h", $time, e.lmin, g.lmin); errors++;
				end
				if (g.cnt !== e.cnt) begin
					$display("%0t: segment_total exp %h got %h", $time, e.cnt, g.cnt); errors++;
				end
			end
		end
		if (hold_rx) begin
			out_stall <= 1'b1;
		end else if (rx_gap > 0) begin
			rx_gap <= rx_gap - 1;
			out_stall <= 1'b1;
		end else if (!no_idle && $urandom_range(0, 12) == 0) begin
			rx_gap <= $urandom_range(0, 8);
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	// watchdog: cycles without any accepted word or taken result
	int quiet = 0;
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet <= 0;
		else quiet <= quiet + 1;
		if (quiet >= QUIET_LIMIT) begin
			$display("FAIL frustum_segment_stats_accumulator");
			$finish;
		end
	end

	initial begin
		acc_vol = 0; acc_area = 0; acc_len = 0;
		len_max = 0; len_min = '1; seg_cnt = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// directed: zero length, extremes, saturation, restart
		pending_words.push_back(mk_seg(0, 0, 0, 0, 0, 0, 0, 0, 0));
		pending_words.push_back(mk_seg(5, 6, 7, 16'h0100, 5, 6, 7, 16'hFFFF, 0));
		pending_words.push_back(mk_seg(20'h80000, 20'h80000, 20'h80000, 16'hFFFF,
			20'h7FFFF, 20'h7FFFF, 20'h7FFFF, 16'hFFFF, 0));
		pending_words.push_back(mk_seg(20'h7FFFF, 20'h7FFFF, 20'h7FFFF, 16'hFFFF,
			20'h80000, 20'h80000, 20'h80000, 16'h0, 0));
		pending_words.push_back(mk_seg(20'h80000, 0, 0, 0, 20'h7FFFF, 0, 0, 16'hFFFF, 1));
		pending_words.push_back(mk_seg(0, 20'h100, 0, 16'h100, 0, 0, 0, 16'h100, 0));
		pending_words.push_back(mk_seg(20'hFFFFF, 20'hFFFFF, 20'hFFFFF, 16'h8000,
			0, 0, 0, 16'h7FFF, 0));
		pending_words.push_back(mk_seg(1, 2, 3, 16'h5555, 20'hAAAAA, 20'h55555, 20'hAAAAA,
			16'hAAAA, 1));
		// many huge segments to drive the sums toward saturation
		for (int i = 0; i < 12; i++)
			pending_words.push_back(mk_seg(20'h80000, 20'h80000, 20'h80000, 16'hFFFF,
				20'h7FFFF, 20'h7FFFF, 20'h7FFFF, 16'hFFFF, 0));
		wait (pending_words.size() == 0 && expected_stats.size() == 0);

		// receiver holds off long while the sender keeps offering
		hold_rx = 1;
		for (int i = 0; i < 40; i++) pending_words.push_back(rand_seg());
		repeat (1500) @(posedge clk);
		hold_rx = 0;
		wait (pending_words.size() == 0 && expected_stats.size() == 0);

		// sender pauses until every result has drained
		for (int i = 0; i < 400; i++) pending_words.push_back(rand_seg());
		wait (pending_words.size() == 0);
		hold_tx = 1;
		wait (!in_valid && expected_stats.size() == 0);
		hold_tx = 0;

		for (int i = 0; i < N_RANDOM - 700; i++) pending_words.push_back(rand_seg());
		wait (pending_words.size() == 0);
		no_idle = 1;
		for (int i = 0; i < 260; i++) pending_words.push_back(rand_seg());
		wait (pending_words.size() == 0);
		wait (!in_valid && expected_stats.size() == 0);
		repeat (200) @(posedge clk);
		if (errors == 0) $display("PASS frustum_segment_stats_accumulator");
		else $display("FAIL frustum_segment_stats_accumulator");
		$finish;
	end

endmodule

### filelist.f
design/fss_pkg.sv
design/fss_mul.sv
design/fss_root.sv
design/frustum_segment_stats_accumulator.sv
dv/tb_frustum_segment_stats_accumulator.sv
